// ===== src/collision_ttc_risk_stager_assert.svh =====
// Assertion macros for the collision TTC risk stager.
// Used by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef COLLISION_TTC_RISK_STAGER_ASSERT_SVH
`define COLLISION_TTC_RISK_STAGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("collision_ttc_risk_stager: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CTRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("collision_ttc_risk_stager: assertion failed");

`endif

// ===== src/ctrs_pkg.sv =====
// Shared types and constants of the collision TTC risk stager.
// Used by the controller, the datapath and the top level; depends on nothing.
package ctrs_pkg;

  localparam logic [31:0] NO_HIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] TTC_LIMIT = 32'd4000000000;

  localparam int SQ_W       = 57;
  localparam int SQRT_STEPS = 29;
  localparam int DIV_STEPS  = 32;

  localparam logic [2:0] REG_TTC_WARN    = 3'd0;
  localparam logic [2:0] REG_TTC_EMERG   = 3'd1;
  localparam logic [2:0] REG_TTC_UNAVOID = 3'd2;
  localparam logic [2:0] REG_AIRBAG_MIN  = 3'd3;
  localparam logic [2:0] REG_EVENT_GAP   = 3'd4;
  localparam logic [2:0] REG_SAMPLE_AGE  = 3'd5;

  localparam logic [1:0] LAMP_OFF   = 2'd0;
  localparam logic [1:0] LAMP_WARN  = 2'd1;
  localparam logic [1:0] LAMP_EMERG = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EARLY,
    CMD_DIVLIN,
    CMD_SQV,
    CMD_DISC,
    CMD_NOHIT,
    CMD_K1,
    CMD_K2,
    CMD_SQRT,
    CMD_DIVR1,
    CMD_DIVR2,
    CMD_DIV,
    CMD_FINQ,
    CMD_FINL,
    CMD_STAGE
  } cmd_t;

  typedef struct packed {
    logic early;
    logic lin;
    logic disc_neg;
  } dp_status_t;

endpackage

// ===== src/ctrs_ctrl.sv =====
// Sequencer of the collision TTC risk stager.
// Depends on ctrs_pkg; drives the datapath commands and the handshakes.
module ctrs_ctrl import ctrs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t sts,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_DISC, S_CHK, S_K2, S_SQRT, S_R1, S_DIV1,
    S_R2, S_DIV2, S_FINQ, S_DIVL, S_FINL, S_STAGE
  } state_t;

  state_t     state;
  logic [4:0] cnt;
  logic       slot_free;
  logic       out_valid_next;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (state == S_STAGE && slot_free) out_valid_next = 1'b1;
  end

  always_comb begin
    unique case (state)
      S_IDLE:  cmd = in_valid ? CMD_LOAD : CMD_NONE;
      S_CLASS: begin
        if (sts.early) cmd = CMD_EARLY;
        else if (sts.lin) cmd = CMD_DIVLIN;
        else cmd = CMD_SQV;
      end
      S_DISC:  cmd = CMD_DISC;
      S_CHK:   cmd = sts.disc_neg ? CMD_NOHIT : CMD_K1;
      S_K2:    cmd = CMD_K2;
      S_SQRT:  cmd = CMD_SQRT;
      S_R1:    cmd = CMD_DIVR1;
      S_R2:    cmd = CMD_DIVR2;
      S_DIV1, S_DIV2, S_DIVL: cmd = CMD_DIV;
      S_FINQ:  cmd = CMD_FINQ;
      S_FINL:  cmd = CMD_FINL;
      S_STAGE: cmd = slot_free ? CMD_STAGE : CMD_NONE;
      default: cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_CLASS;
        S_CLASS: begin
          cnt <= 5'd0;
          if (sts.early) state <= S_STAGE;
          else if (sts.lin) state <= S_DIVL;
          else state <= S_DISC;
        end
        S_DISC:  state <= S_CHK;
        S_CHK:   state <= sts.disc_neg ? S_STAGE : S_K2;
        S_K2: begin
          cnt   <= 5'd0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(SQRT_STEPS - 1)) state <= S_R1;
        end
        S_R1: begin
          cnt   <= 5'd0;
          state <= S_DIV1;
        end
        S_DIV1: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_STEPS - 1)) state <= S_R2;
        end
        S_R2: begin
          cnt   <= 5'd0;
          state <= S_DIV2;
        end
        S_DIV2: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_STEPS - 1)) state <= S_FINQ;
        end
        S_DIVL: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_STEPS - 1)) state <= S_FINL;
        end
        S_FINQ, S_FINL: state <= S_STAGE;
        S_STAGE: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/ctrs_dpath.sv =====
// Datapath of the collision TTC risk stager: configuration, TTC arithmetic,
// staging, event limiters and result registers. Depends on ctrs_pkg.
module ctrs_dpath import ctrs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output dp_status_t         sts,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [31:0]        now_time_ms,
  input  logic [31:0]        sample_time_ms,
  input  logic               object_seen,
  input  logic [17:0]        distance_mm,
  input  logic signed [17:0] closing_speed,
  input  logic signed [17:0] closing_accel,
  output logic [31:0]        ttc_out_ms,
  output logic [1:0]         lamp_level,
  output logic               emergency_active,
  output logic               airbag_active,
  output logic               sample_fresh,
  output logic               send_lamp_one,
  output logic               send_lamp_two,
  output logic               send_lamp_off,
  output logic               send_emerg_on,
  output logic               send_emerg_off,
  output logic               send_accident_note,
  output logic               send_airbag_fire
);

  logic [15:0] ttc_warn_ms, ttc_emergency_ms, ttc_airbag_ms;
  logic [16:0] airbag_min_speed;
  logic [15:0] min_event_gap_ms, max_sample_age_ms;

  logic [31:0] last_lamp_one_time, last_lamp_two_time, last_emerg_time;
  logic [31:0] last_note_time, last_airbag_time;

  logic [31:0]        now_r, smp_r;
  logic               seen_r;
  logic [17:0]        d_r;
  logic signed [17:0] v_r, a_r;

  logic signed [38:0] disc;
  logic [SQ_W-1:0]    x, r, sbit;
  logic [17:0]        rem, dvs;
  logic [31:0]        dvd, q1, ttc;
  logic               ok1, ok2;

  logic [31:0]        age;
  logic               fresh;
  logic [SQ_W-1:0]    sq_sum;
  logic [18:0]        rem_sh;
  logic               qbit;
  logic [31:0]        v1000, s32, n1, n2, n_sel, n_mag, ms;
  logic               a_pos, a_neg, ok_sel;
  logic [17:0]        a_mag;

  logic fire_l1, fire_l2, fire_em, fire_nt, fire_ab;
  logic warn_hit, emerg_hit, air_hit;

  assign age   = (now_r >= smp_r) ? (now_r - smp_r) : 32'd0;
  assign fresh = (age <= {16'd0, max_sample_age_ms});

  assign sts.early    = !fresh || !seen_r || (d_r == 18'd0) ||
                        ((v_r <= 18'sd1) && (a_r <= 18'sd0));
  assign sts.lin      = (a_r == 18'sd0);
  assign sts.disc_neg = disc[38];

  assign sq_sum = r + sbit;
  assign rem_sh = {rem, dvd[31]};
  assign qbit   = (rem_sh >= {1'b0, dvs});

  assign v1000 = {{14{v_r[17]}}, v_r} * 32'd1000;
  assign s32   = {3'd0, r[28:0]};
  assign n1    = s32 - v1000;
  assign n2    = 32'd0 - s32 - v1000;
  assign n_sel = (cmd == CMD_DIVR1) ? n1 : n2;
  assign n_mag = n_sel[31] ? (32'd0 - n_sel) : n_sel;
  assign a_pos = !a_r[17] && (a_r != 18'sd0);
  assign a_neg = a_r[17];
  assign a_mag = a_neg ? (18'd0 - a_r) : a_r;
  assign ok_sel = (a_pos && !n_sel[31] && (n_sel != 32'd0)) || (a_neg && n_sel[31]);

  always_comb begin
    if (ok1 && ok2) ms = (dvd < q1) ? dvd : q1;
    else if (ok1) ms = q1;
    else if (ok2) ms = dvd;
    else ms = NO_HIT;
  end

  assign fire_l1 = (last_lamp_one_time == 32'd0) ||
                   ((now_r - last_lamp_one_time) >= {16'd0, min_event_gap_ms});
  assign fire_l2 = (last_lamp_two_time == 32'd0) ||
                   ((now_r - last_lamp_two_time) >= {16'd0, min_event_gap_ms});
  assign fire_em = (last_emerg_time == 32'd0) ||
                   ((now_r - last_emerg_time) >= {16'd0, min_event_gap_ms});
  assign fire_nt = (last_note_time == 32'd0) ||
                   ((now_r - last_note_time) >= {16'd0, min_event_gap_ms});
  assign fire_ab = (last_airbag_time == 32'd0) ||
                   ((now_r - last_airbag_time) >= {16'd0, min_event_gap_ms});

  assign warn_hit  = (ttc <= {16'd0, ttc_warn_ms});
  assign emerg_hit = (ttc <= {16'd0, ttc_emergency_ms});
  assign air_hit   = (ttc <= {16'd0, ttc_airbag_ms}) &&
                     ($signed({v_r[17], v_r}) >= $signed({2'b00, airbag_min_speed}));

  always_ff @(posedge clk) begin
    if (rst) begin
      ttc_warn_ms        <= 16'd1500;
      ttc_emergency_ms   <= 16'd800;
      ttc_airbag_ms      <= 16'd300;
      airbag_min_speed   <= 17'd3000;
      min_event_gap_ms   <= 16'd100;
      max_sample_age_ms  <= 16'd500;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TTC_WARN:    ttc_warn_ms        <= cfg_data[15:0];
        REG_TTC_EMERG:   ttc_emergency_ms   <= cfg_data[15:0];
        REG_TTC_UNAVOID: ttc_airbag_ms      <= cfg_data[15:0];
        REG_AIRBAG_MIN:  airbag_min_speed   <= cfg_data[16:0];
        REG_EVENT_GAP:   min_event_gap_ms   <= cfg_data[15:0];
        REG_SAMPLE_AGE:  max_sample_age_ms  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_lamp_one_time <= 32'd0;
      last_lamp_two_time <= 32'd0;
      last_emerg_time    <= 32'd0;
      last_note_time     <= 32'd0;
      last_airbag_time   <= 32'd0;
    end else if (cmd == CMD_STAGE && fresh && seen_r) begin
      if (ttc == NO_HIT) begin
        if (fire_em) last_emerg_time    <= now_r;
        if (fire_l1) last_lamp_one_time <= now_r;
      end else begin
        if (warn_hit && fire_l1) last_lamp_one_time <= now_r;
        if (emerg_hit) begin
          if (fire_em) last_emerg_time    <= now_r;
          if (fire_l2) last_lamp_two_time <= now_r;
          if (fire_nt) last_note_time     <= now_r;
        end
        if (air_hit && fire_ab) last_airbag_time <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        now_r  <= now_time_ms;
        smp_r  <= sample_time_ms;
        seen_r <= object_seen;
        d_r    <= distance_mm;
        v_r    <= closing_speed;
        a_r    <= closing_accel;
      end
      CMD_EARLY:  ttc <= (d_r == 18'd0) ? 32'd0 : NO_HIT;
      CMD_DIVLIN: begin
        dvd <= {14'd0, d_r} * 32'd1000;
        dvs <= v_r;
        rem <= 18'd0;
      end
      CMD_SQV:    disc <= 39'(v_r * v_r);
      CMD_DISC:   disc <= disc + 39'(2 * 39'(a_r * $signed({1'b0, d_r})));
      CMD_NOHIT:  ttc <= NO_HIT;
      CMD_K1:     x <= {20'd0, disc[36:0]} * 57'd1000;
      CMD_K2: begin
        x    <= x * 57'd1000;
        r    <= '0;
        sbit <= SQ_W'(1) << (SQ_W - 1);
      end
      CMD_SQRT: begin
        if (x >= sq_sum) begin
          x <= x - sq_sum;
          r <= (r >> 1) + sbit;
        end else begin
          r <= r >> 1;
        end
        sbit <= sbit >> 2;
      end
      CMD_DIVR1: begin
        ok1 <= ok_sel;
        dvd <= n_mag;
        dvs <= a_mag;
        rem <= 18'd0;
      end
      CMD_DIVR2: begin
        q1  <= dvd;
        ok2 <= ok_sel;
        dvd <= n_mag;
        dvs <= a_mag;
        rem <= 18'd0;
      end
      CMD_DIV: begin
        rem <= qbit ? 18'(rem_sh - {1'b0, dvs}) : rem_sh[17:0];
        dvd <= {dvd[30:0], qbit};
      end
      CMD_FINQ:   ttc <= (ms > TTC_LIMIT) ? NO_HIT : ms;
      CMD_FINL:   ttc <= (dvd > TTC_LIMIT) ? NO_HIT : dvd;
      CMD_STAGE: begin
        ttc_out_ms         <= NO_HIT;
        lamp_level         <= LAMP_OFF;
        emergency_active   <= 1'b0;
        airbag_active      <= 1'b0;
        sample_fresh       <= fresh;
        send_lamp_one      <= 1'b0;
        send_lamp_two      <= 1'b0;
        send_lamp_off      <= 1'b0;
        send_emerg_on      <= 1'b0;
        send_emerg_off     <= 1'b0;
        send_accident_note <= 1'b0;
        send_airbag_fire   <= 1'b0;
        if (fresh && seen_r) begin
          ttc_out_ms <= ttc;
          if (ttc == NO_HIT) begin
            send_emerg_off <= fire_em;
            send_lamp_off  <= fire_l1;
          end else begin
            if (emerg_hit) lamp_level <= LAMP_EMERG;
            else if (warn_hit) lamp_level <= LAMP_WARN;
            send_lamp_one      <= warn_hit && fire_l1;
            emergency_active   <= emerg_hit;
            send_emerg_on      <= emerg_hit && fire_em;
            send_lamp_two      <= emerg_hit && fire_l2;
            send_accident_note <= emerg_hit && fire_nt;
            airbag_active      <= air_hit;
            send_airbag_fire   <= air_hit && fire_ab;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/collision_ttc_risk_stager.sv =====
// Top level of the collision TTC risk stager: sequencer plus datapath.
// Depends on ctrs_pkg, ctrs_ctrl, ctrs_dpath and the assertion macro header.
//
//  Channel   Signals                               Transfer when
//  in        in_valid/in_ready + six input fields  in_valid && in_ready
//  out       out_valid/out_ready + twelve results  out_valid && out_ready
//  cfg       cfg_valid/cfg_ready, cfg_index/data   cfg_valid && cfg_ready
//
// A stale sample, a missing object or a trivial TTC is staged after classification, a
// negative discriminant after the discriminant check, the linear case after one 32-step
// serial division, and the quadratic case after the 29-step serial square root and two
// 32-step serial divisions that share one divider.
// Reset is synchronous and restores the register defaults and clears all limiters.
// A new input is taken once the previous one is staged; a stalled output holds staging.
`include "collision_ttc_risk_stager_assert.svh"
module collision_ttc_risk_stager import ctrs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        now_time_ms,
  input  logic [31:0]        sample_time_ms,
  input  logic               object_seen,
  input  logic [17:0]        distance_mm,
  input  logic signed [17:0] closing_speed,
  input  logic signed [17:0] closing_accel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        ttc_out_ms,
  output logic [1:0]         lamp_level,
  output logic               emergency_active,
  output logic               airbag_active,
  output logic               sample_fresh,
  output logic               send_lamp_one,
  output logic               send_lamp_two,
  output logic               send_lamp_off,
  output logic               send_emerg_on,
  output logic               send_emerg_off,
  output logic               send_accident_note,
  output logic               send_airbag_fire,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cmd_t       cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  ctrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctrs_dpath u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .now_time_ms        (now_time_ms),
    .sample_time_ms     (sample_time_ms),
    .object_seen        (object_seen),
    .distance_mm        (distance_mm),
    .closing_speed      (closing_speed),
    .closing_accel      (closing_accel),
    .ttc_out_ms         (ttc_out_ms),
    .lamp_level         (lamp_level),
    .emergency_active   (emergency_active),
    .airbag_active      (airbag_active),
    .sample_fresh       (sample_fresh),
    .send_lamp_one      (send_lamp_one),
    .send_lamp_two      (send_lamp_two),
    .send_lamp_off      (send_lamp_off),
    .send_emerg_on      (send_emerg_on),
    .send_emerg_off     (send_emerg_off),
    .send_accident_note (send_accident_note),
    .send_airbag_fire   (send_airbag_fire)
  );

  `CTRS_ASSERT_NEXT(a_busy_after_load, in_valid && in_ready, !in_ready)
  `CTRS_ASSERT_NOW(a_emerg_lamp, out_valid && emergency_active, lamp_level == LAMP_EMERG)
  `CTRS_ASSERT_NOW(a_stale_clear, out_valid && !sample_fresh,
                   ttc_out_ms == NO_HIT && !emergency_active && !send_lamp_off)
  `CTRS_ASSERT_NOW(a_airbag_fire, out_valid && send_airbag_fire, airbag_active)

endmodule

// ===== sim/collision_ttc_risk_stager_test.sv =====
// Self-checking testbench for the collision TTC risk stager: random and directed ticks,
// register phases, and a class-based scoreboard that predicts every result.
// Depends on ctrs_pkg and the collision_ttc_risk_stager RTL.
module collision_ttc_risk_stager_test import ctrs_pkg::*; ();

  typedef struct packed {
    logic [31:0] ttc;
    logic [1:0]  lamp;
    logic        emerg;
    logic        airbag;
    logic        fresh;
    logic        l1;
    logic        l2;
    logic        loff;
    logic        eon;
    logic        eoff;
    logic        note;
    logic        fire;
  } verdict_t;

  class risk_scoreboard;
    logic [31:0] warn_ms, emerg_ms, unavoid_ms, gap_ms, age_ms;
    logic [16:0] bag_speed;
    logic [31:0] t_l1, t_l2, t_em, t_note, t_bag;
    verdict_t pending[$];
    int errors;

    function new();
      warn_ms = 1500; emerg_ms = 800; unavoid_ms = 300;
      bag_speed = 3000; gap_ms = 100; age_ms = 500;
      t_l1 = 0; t_l2 = 0; t_em = 0; t_note = 0; t_bag = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_TTC_WARN:    warn_ms = val[15:0];
        REG_TTC_EMERG:   emerg_ms = val[15:0];
        REG_TTC_UNAVOID: unavoid_ms = val[15:0];
        REG_AIRBAG_MIN:  bag_speed = val[16:0];
        REG_EVENT_GAP:   gap_ms = val[15:0];
        REG_SAMPLE_AGE:  age_ms = val[15:0];
        default: ;
      endcase
    endfunction

    function automatic bit gate(ref logic [31:0] last, input logic [31:0] now);
      logic [31:0] diff;
      diff = now - last;
      if (last == 0 || diff >= gap_ms) begin
        last = now;
        return 1;
      end
      return 0;
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic logic [31:0] time_to_hit(longint d, longint v, longint a);
      longint unsigned ms, q;
      longint disc, s, n;
      bit have;
      have = 0;
      if (d <= 0) return 0;
      if (v <= 1 && a <= 0) return NO_HIT;
      if (a == 0) begin
        ms = longint'(d * 1000) / v;
      end else begin
        disc = v * v + 2 * a * d;
        if (disc < 0) return NO_HIT;
        s = longint'(root64(longint'(disc) * 1000000));
        ms = 0;
        for (int k = 0; k < 2; k++) begin
          n = (k == 0) ? (s - 1000 * v) : (-s - 1000 * v);
          if ((a > 0 && n > 0) || (a < 0 && n < 0)) begin
            q = (n < 0) ? longint'(-n) / longint'(-a) : n / a;
            if (!have || q < ms) begin
              ms = q;
              have = 1;
            end
          end
        end
        if (!have) return NO_HIT;
      end
      if (ms > TTC_LIMIT) return NO_HIT;
      return ms[31:0];
    endfunction

    function void note_tick(logic [31:0] now, logic [31:0] smp, logic seen,
                            logic [17:0] dist_mm, logic signed [17:0] spd,
                            logic signed [17:0] acc);
      verdict_t r;
      logic [31:0] age;
      r = '0;
      r.ttc = NO_HIT;
      age = (now >= smp) ? now - smp : 0;
      if (age <= age_ms) begin
        r.fresh = 1;
        if (seen) begin
          r.ttc = time_to_hit(longint'(dist_mm), longint'(spd), longint'(acc));
          if (r.ttc == NO_HIT) begin
            r.eoff = gate(t_em, now);
            r.loff = gate(t_l1, now);
          end else begin
            if (r.ttc <= warn_ms) begin
              r.lamp = LAMP_WARN;
              r.l1 = gate(t_l1, now);
            end
            if (r.ttc <= emerg_ms) begin
              r.lamp = LAMP_EMERG;
              r.emerg = 1;
              r.eon = gate(t_em, now);
              r.l2 = gate(t_l2, now);
              r.note = gate(t_note, now);
            end
            if (r.ttc <= unavoid_ms && longint'(spd) >= longint'(bag_speed)) begin
              r.airbag = 1;
              r.fire = gate(t_bag, now);
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(verdict_t got);
      verdict_t w;
      if (pending.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.ttc !== w.ttc) begin
        $error("ttc_out_ms exp %0d got %0d", w.ttc, got.ttc); errors++;
      end
      if (got.lamp !== w.lamp) begin
        $error("lamp_level exp %0d got %0d", w.lamp, got.lamp); errors++;
      end
      if (got.emerg !== w.emerg) begin
        $error("emergency_active exp %0d got %0d", w.emerg, got.emerg); errors++;
      end
      if (got.airbag !== w.airbag) begin
        $error("airbag_active exp %0d got %0d", w.airbag, got.airbag); errors++;
      end
      if (got.fresh !== w.fresh) begin
        $error("sample_fresh exp %0d got %0d", w.fresh, got.fresh); errors++;
      end
      if (got.l1 !== w.l1) begin
        $error("send_lamp_one exp %0d got %0d", w.l1, got.l1); errors++;
      end
      if (got.l2 !== w.l2) begin
        $error("send_lamp_two exp %0d got %0d", w.l2, got.l2); errors++;
      end
      if (got.loff !== w.loff) begin
        $error("send_lamp_off exp %0d got %0d", w.loff, got.loff); errors++;
      end
      if (got.eon !== w.eon) begin
        $error("send_emerg_on exp %0d got %0d", w.eon, got.eon); errors++;
      end
      if (got.eoff !== w.eoff) begin
        $error("send_emerg_off exp %0d got %0d", w.eoff, got.eoff); errors++;
      end
      if (got.note !== w.note) begin
        $error("send_accident_note exp %0d got %0d", w.note, got.note); errors++;
      end
      if (got.fire !== w.fire) begin
        $error("send_airbag_fire exp %0d got %0d", w.fire, got.fire); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [31:0] now_time_ms = 0, sample_time_ms = 0;
  logic object_seen = 0;
  logic [17:0] distance_mm = 0;
  logic signed [17:0] closing_speed = 0, closing_accel = 0;
  logic out_valid, out_ready = 0;
  logic [31:0] ttc_out_ms;
  logic [1:0] lamp_level;
  logic emergency_active, airbag_active, sample_fresh, send_lamp_one, send_lamp_two;
  logic send_lamp_off, send_emerg_on, send_emerg_off, send_accident_note;
  logic send_airbag_fire;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  risk_scoreboard board = new();
  logic [31:0] clock_ms = 0;
  int hold_off = 0;
  int cycles = 0;

  collision_ttc_risk_stager i_dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("collision_ttc_risk_stager: mismatch");
      $finish;
    end
    if (!rst && in_valid && in_ready)
      board.note_tick(now_time_ms, sample_time_ms, object_seen, distance_mm,
                      closing_speed, closing_accel);
    if (!rst && out_valid && out_ready)
      board.check_result({ttc_out_ms, lamp_level, emergency_active, airbag_active,
                          sample_fresh, send_lamp_one, send_lamp_two, send_lamp_off,
                          send_emerg_on, send_emerg_off, send_accident_note,
                          send_airbag_fire});
  end

  // The receiver stalls on its own pattern; a long hold-off can be requested.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= (cycles % 512 < 200) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_tick(logic [31:0] now, logic [31:0] smp, logic seen,
                           logic [17:0] dist_mm, logic signed [17:0] spd,
                           logic signed [17:0] acc);
    @(negedge clk);
    in_valid <= 1;
    now_time_ms <= now;
    sample_time_ms <= smp;
    object_seen <= seen;
    distance_mm <= dist_mm;
    closing_speed <= spd;
    closing_accel <= acc;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_in(int n);
    @(negedge clk);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [17:0] pick_signed();
    case ($urandom_range(0, 4))
      0: return 18'(18'sd100000 - $urandom_range(0, 3));
      1: return 18'(-18'sd100000 + $urandom_range(0, 3));
      2: return 18'($urandom_range(0, 4) - 2);
      3: return 18'($urandom_range(0, 100000));
      default: return -$signed({1'b0, 17'($urandom_range(0, 100000))});
    endcase
  endfunction

  task automatic random_phase(int n);
    int burst;
    logic [31:0] now, smp;
    logic [17:0] dist_mm;
    logic signed [17:0] spd, acc;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        idle_in($urandom_range(0, 30));
        burst = $urandom_range(1, 20);
      end
      burst--;
      if ($urandom_range(0, 9) == 0) now = $urandom();
      else begin
        clock_ms += $urandom_range(0, 250);
        now = clock_ms;
      end
      case ($urandom_range(0, 9))
        0: smp = $urandom();
        1: smp = now - $urandom_range(400, 700);
        default: smp = now - $urandom_range(0, 60);
      endcase
      dist_mm = ($urandom_range(0, 7) == 0) ? 18'($urandom()) : 18'($urandom_range(0, 20000));
      spd = pick_signed();
      acc = ($urandom_range(0, 3) == 0) ? 18'sd0 : pick_signed();
      if (spd > 0 && $urandom_range(0, 1) == 0) spd = 18'($urandom_range(2000, 30000));
      send_tick(now, smp, $urandom_range(0, 7) != 0, dist_mm, spd, acc);
    end
    idle_in(0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed ticks: stale, missing object, zero distance, field extremes, staging.
    send_tick(32'd0, 32'd0, 1, 18'd1000, 18'sd10000, 18'sd0);
    send_tick(32'd1000, 32'd400, 1, 18'd500, 18'sd10000, 18'sd0);
    send_tick(32'd1000, 32'd499, 1, 18'd500, 18'sd10000, 18'sd0);
    send_tick(32'd1050, 32'd2000, 0, 18'd500, 18'sd10000, 18'sd0);
    send_tick(32'd1100, 32'd1100, 1, 18'd0, 18'sd0, 18'sd0);
    send_tick(32'd1200, 32'd1200, 1, 18'h3FFFF, 18'sd1, 18'sd0);
    send_tick(32'd1210, 32'd1210, 1, 18'd2000, 18'sd2, 18'sd0);
    send_tick(32'd1300, 32'd1300, 1, 18'd3000, 18'sd100000, 18'sd0);
    send_tick(32'd1310, 32'd1310, 1, 18'd3000, 18'sd100000, 18'sd0);
    send_tick(32'd1500, 32'd1500, 1, 18'd10000, 18'sd20000, 18'sd5000);
    send_tick(32'd1600, 32'd1600, 1, 18'd10000, 18'sd20000, -18'sd100000);
    send_tick(32'd1700, 32'd1700, 1, 18'd10000, -18'sd100000, 18'sd100000);
    send_tick(32'd1800, 32'd1800, 1, 18'h3FFFF, -18'sd5, 18'sd1);
    send_tick(32'd1900, 32'd1900, 1, 18'd100, -18'sd100000, -18'sd100000);
    send_tick(32'hFFFFFFFF, 32'hFFFFFF00, 1, 18'd20000, 18'sd15000, 18'sd0);
    send_tick(32'hFFFFFFFF, 32'h0, 1, 18'd20000, 18'sd15000, 18'sd0);
    send_tick(32'd50, 32'd50, 1, 18'd1, 18'sd100000, 18'sd100000);
    idle_in(0);
    drain();

    random_phase(200);
    drain();

    // Extreme settings, then the receiver holds off while the sender keeps going.
    write_reg(REG_TTC_WARN, 32'hFFFF);
    write_reg(REG_TTC_EMERG, 32'hFFFF);
    write_reg(REG_TTC_UNAVOID, 32'hFFFF);
    write_reg(REG_AIRBAG_MIN, 32'd0);
    write_reg(REG_EVENT_GAP, 32'd0);
    write_reg(REG_SAMPLE_AGE, 32'hFFFF);
    hold_off = 400;
    random_phase(150);
    drain();

    write_reg(REG_TTC_WARN, 32'd0);
    write_reg(REG_TTC_EMERG, 32'd0);
    write_reg(REG_TTC_UNAVOID, 32'd0);
    write_reg(REG_AIRBAG_MIN, 32'd100000);
    write_reg(REG_EVENT_GAP, 32'hFFFF);
    write_reg(REG_SAMPLE_AGE, 32'd0);
    random_phase(150);
    drain();

    write_reg(REG_TTC_WARN, 32'd3000);
    write_reg(REG_TTC_EMERG, 32'd1500);
    write_reg(REG_TTC_UNAVOID, 32'd700);
    write_reg(REG_AIRBAG_MIN, 32'd1);
    write_reg(REG_EVENT_GAP, 32'd150);
    write_reg(REG_SAMPLE_AGE, 32'd300);
    random_phase(200);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("collision_ttc_risk_stager: match");
    end else begin
      $display("collision_ttc_risk_stager: mismatch");
    end
    $finish;
  end
endmodule
